// ===== rtl/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types for the trial division prime test
// status that the remainder unit reports back to the sequencer
// ----------------------------------------------------------------------------
package tdpt_pkg;

   typedef struct packed {
      logic done;   // one-cycle pulse, remainder is final
      logic zero;   // remainder is zero, valid with done
   } rem_status_type;

endpackage

// ===== rtl/tdpt_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tdpt_rem_unit: bit-serial remainder unit
// restoring division, one dividend bit per cycle through one subtractor
// ----------------------------------------------------------------------------
module tdpt_rem_unit #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [WIDTH-1:0]        dividend,
   input  logic [WIDTH/2:0]        divisor,
   output tdpt_pkg::rem_status_type status
);

   localparam int DW = WIDTH / 2 + 1;
   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [DW:0]      trial;
   logic [DW:0]      diff;

   // shift the next dividend bit in and try one subtract
   assign trial = {rem_ff, shift_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CW'(WIDTH - 1);
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         // no borrow: remainder below twice the divisor, so the difference fits
         rem_in   = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule

// ===== rtl/trial_division_prime_test_top.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_top: trial division primality test
// tests one signed integer per command beat and reports whether it is prime
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken at a rising edge with start high and busy low;
//   req_number is a two's complement integer, only its low WIDTH bits count
//   (bit WIDTH-1 is the sign). one result beat follows: rsp_valid is high for
//   exactly one cycle with rsp_is_prime. the receiver cannot stall, so the
//   result is simply shown once and gone.
// sequencing
//   negative values, zero and one: result in the cycle after the command,
//   and busy stays low. otherwise each trial divisor takes one bound
//   compare (S_CHECK), then a pass through the bit-serial remainder unit
//   (S_DIV) until its done pulse; a 32-bit prime near 2^31 tries about
//   46340 divisors, so the serial remainder unit dominates the run time.
//   for these, busy is high the whole time and drops in the cycle the
//   result beat is shown, so the next command can be taken there.
// reset
//   synchronous, active high: sequencer returns to idle, no result pending.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_number,
   output logic        rsp_valid,
   output logic        rsp_is_prime
);

   localparam int DW = WIDTH / 2 + 1;   // divisor stays below 2^(WIDTH/2+1)

   // sequencer codes
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;      // value under test
   logic [DW-1:0]    d_ff, d_in;      // current trial divisor
   logic [WIDTH-1:0] sq_ff, sq_in;    // d squared, kept by running sum
   logic             valid_ff, valid_in;
   logic             prime_ff, prime_in;
   logic             rem_start;

   logic [WIDTH+31:0] num_ext;
   logic [WIDTH-1:0]  num;

   tdpt_pkg::rem_status_type rem_status;

   // fit the 32-bit field to WIDTH: drop high bits or zero extend
   assign num_ext = {{WIDTH{1'b0}}, req_number};
   assign num     = num_ext[WIDTH-1:0];

   tdpt_rem_unit #(
      .WIDTH(WIDTH)
   ) u_rem (
      .clock   (clock),
      .reset   (reset),
      .start   (rem_start),
      .dividend(n_ff),
      .divisor (d_ff),
      .status  (rem_status)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      valid_in  = 1'b0;
      prime_in  = prime_ff;
      rem_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in  = num;
               d_in  = DW'(2);
               sq_in = WIDTH'(4);
               // negative, zero and one are never prime
               if (num[WIDTH-1] || num <= WIDTH'(1)) begin
                  valid_in = 1'b1;
                  prime_in = 1'b0;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // bound passed without a divisor: prime
            if (sq_ff > n_ff) begin
               valid_in = 1'b1;
               prime_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  valid_in = 1'b1;
                  prime_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  d_in     = d_ff + 1'b1;
                  sq_in    = sq_ff + WIDTH'({d_ff, 1'b1});
                  state_in = S_CHECK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      prime_ff <= prime_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: trial division prime test, self-checking
// drives signed integers through the start/busy command port and compares
// each rsp_is_prime beat with a table answer or a software trial-division
// predictor; a short table of corner values comes first, then randomized
// values weighted toward cheap items to save simulation cycles
// ----------------------------------------------------------------------------
module testbench;

   localparam int WIDTH          = 32;
   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 100;
   localparam int QUIET_TAIL     = 20;         // last random items with no idling
   localparam int DRAIN_CYCLES   = 2 * (WIDTH + 2) + 8;
   localparam int TIMEOUT_CYCLES = 10_000_000;
   localparam int REPORT_LIMIT   = 10;

   // one row of the directed table; known rows carry their answer
   typedef struct {
      logic [31:0] number;
      bit          known;
      logic        is_prime;
   } corner_row_type;

   localparam int CORNER_ROWS = 20;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_number;
   logic        rsp_valid;
   logic        rsp_is_prime;

   logic        prime_flags_due[$];   // answers owed by the block, oldest first
   int unsigned mismatch_count;
   int unsigned cycle_count;

   trial_division_prime_test_top #(
      .WIDTH(WIDTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_number  (req_number),
      .rsp_valid   (rsp_valid),
      .rsp_is_prime(rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // trial division on the low WIDTH bits; sign bit set means not prime
   function automatic logic prime_by_trial(input logic [31:0] number);
      logic [WIDTH-1:0] field;
      longint unsigned  value;
      longint unsigned  divisor;
      field = number[WIDTH-1:0];
      if (field[WIDTH-1]) begin
         return 1'b0;
      end
      value = field;
      if (value <= 1) begin
         return 1'b0;
      end
      // d*d compare, exact like the block's bound
      for (divisor = 2; divisor * divisor <= value; divisor++) begin
         if (value % divisor == 0) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // hold start high with the beat until the block takes it; the answer is
   // queued at the edge that takes the beat. called right after a rising edge
   task automatic offer_number(input logic [31:0] number, input logic is_prime);
      start      <= 1'b1;
      req_number <= number;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      prime_flags_due.push_back(is_prime);
   endtask

   // drop start for a random burst, scrambling the idle data lines
   task automatic idle_burst();
      start      <= 1'b0;
      req_number <= $urandom;
      repeat ($urandom_range(1, 5)) @(posedge clock);
   endtask

   // result side: the block shows each answer for one cycle, no stall possible
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (prime_flags_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("tb: unexpected result beat, rsp_is_prime=%b", rsp_is_prime);
            end
         end else begin
            logic due;
            due = prime_flags_due.pop_front();
            if (rsp_is_prime !== due) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("tb: rsp_is_prime mismatch, expected %b got %b",
                           due, rsp_is_prime);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      corner_row_type corner_rows[CORNER_ROWS];
      logic [31:0] number;
      int          pick;
      int unsigned factor;

      // corner values: sign extremes, zero and one, two and three, squares on
      // the loop bound, largest even value, and a few primes for the predictor.
      // the largest positive value is itself prime and would cost the full
      // sweep of divisors, so the largest even value stands in for it
      corner_rows = '{
         '{32'h8000_0000, 1'b1, 1'b0},   // most negative
         '{32'hFFFF_FFFF, 1'b1, 1'b0},   // minus one
         '{32'h8000_0002, 1'b1, 1'b0},   // negative, small magnitude bits
         '{32'h0000_0000, 1'b1, 1'b0},   // zero
         '{32'h0000_0001, 1'b1, 1'b0},   // one
         '{32'h0000_0002, 1'b1, 1'b1},   // two, bound fails at once
         '{32'h0000_0003, 1'b1, 1'b1},   // three, bound fails at once
         '{32'h0000_0004, 1'b1, 1'b0},   // smallest composite, d*d equals value
         '{32'h0000_0019, 1'b1, 1'b0},   // 25, factor found only at the bound
         '{32'h0000_0031, 1'b1, 1'b0},   // 49
         '{32'h0000_0005, 1'b1, 1'b1},
         '{32'h7FFF_FFFE, 1'b1, 1'b0},   // largest even value
         '{32'h7FFF_FFFD, 1'b0, 1'b0},   // largest odd below max
         '{32'h5555_5555, 1'b1, 1'b0},   // ends in five, multiple of five
         '{32'h2AAA_AAAA, 1'b1, 1'b0},   // even
         '{32'h0000_0061, 1'b0, 1'b0},   // 97
         '{32'h0000_1EEF, 1'b0, 1'b0},   // 7919
         '{32'h0001_0001, 1'b0, 1'b0},   // 65537
         '{32'h000F_4243, 1'b0, 1'b0},   // 1000003, ~1000 divisors
         '{32'h000F_4241, 1'b0, 1'b0}    // 1000001
      };

      mismatch_count = 0;
      cycle_count    = 0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_number <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, with idling now and then between beats
      foreach (corner_rows[i]) begin
         if ($urandom_range(0, 2) == 0) begin
            idle_burst();
         end
         offer_number(corner_rows[i].number,
                      corner_rows[i].known ? corner_rows[i].is_prime
                                           : prime_by_trial(corner_rows[i].number));
      end

      // random part: mostly cheap values, a tenth of mid-size values that
      // may run a few hundred divisors, none of the full 31-bit sweeps
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // any negative value, every low bit random
            number = $urandom | 32'h8000_0000;
         end else if (pick < 55) begin
            number = $urandom_range(0, 5000);
         end else if (pick < 80) begin
            // big positive value with a small factor: high bits random, quick
            case ($urandom_range(0, 5))
               0:       factor = 2;
               1:       factor = 3;
               2:       factor = 5;
               3:       factor = 7;
               4:       factor = 11;
               default: factor = 13;
            endcase
            number = (($urandom & 32'h7FFF_FFFF) / factor) * factor;
         end else if (pick < 90) begin
            number = $urandom_range(5001, 200000);
         end else begin
            case ($urandom_range(0, 7))
               0:       number = 32'h0000_0000;
               1:       number = 32'h0000_0001;
               2:       number = 32'h0000_0002;
               3:       number = 32'h0000_0003;
               4:       number = 32'h0000_0004;
               5:       number = 32'hFFFF_FFFF;
               6:       number = 32'h7FFF_FFFE;
               default: number = 32'h8000_0000;
            endcase
         end
         // no idling in the tail, so beats land right as busy drops
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            idle_burst();
         end
         offer_number(number, prime_by_trial(number));
      end

      start      <= 1'b0;
      req_number <= '0;

      // wait for every owed answer, then watch a little longer for strays
      while (prime_flags_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
